// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SGM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SGM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sgm_pkg.sv -----
// types, constants and helper functions of the spin gesture menu controller
// no dependencies
package sgm_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ACC_W      = 15;
  localparam int unsigned YAW_W      = 32;
  localparam int unsigned TILT_W     = 16;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WARMUP_MS         = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REQUIRED_SWITCHES = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_TIMEOUT      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_TOLERANCE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_LIMIT_MG    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CONFIRM_TARGET    = 3'd5;

  // option codes
  localparam logic [1:0] OPT_UPRIGHT    = 2'd1;
  localparam logic [1:0] OPT_BETWEEN    = 2'd2;
  localparam logic [1:0] OPT_HORIZONTAL = 2'd3;

  localparam logic signed [TILT_W-1:0] TILT_OFFSET_MG = 16'sd50;
  localparam logic [TILT_W-1:0]        TILT_LOW_MG    = 16'd300;
  localparam logic [TILT_W-1:0]        TILT_HIGH_MG   = 16'd850;

  localparam logic [7:0] IDLE_MAX    = 8'hFF;
  localparam logic [5:0] SWITCH_MAX  = 6'h3F;
  localparam logic [2:0] CONFIRM_MAX = 3'h7;
  localparam logic [7:0] BLINK_LAST  = 8'hFF;

  typedef struct packed {
    logic [15:0] warmup_ms;
    logic [5:0]  required_switches;
    logic [7:0]  idle_timeout;
    logic [8:0]  angle_tolerance;
    logic [10:0] level_limit_mg;
    logic [2:0]  confirm_target;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    warmup_ms:         16'd16000,
    required_switches: 6'd12,
    idle_timeout:      8'd40,
    angle_tolerance:   9'd10,
    level_limit_mg:    11'd450,
    confirm_target:    3'd4
  };

  typedef struct packed {
    logic                    menu_on;
    logic [1:0]              sel_opt;
    logic [1:0]              cand_opt;
    logic [2:0]              confirm_cnt;
    logic [7:0]              blink_cnt;
    logic [5:0]              switch_cnt;
    logic [7:0]              idle_cnt;
    logic signed [YAW_W-1:0] last_yaw;
    logic                    turning_pos;
  } st_t;

  localparam st_t ST_RESET = '{
    menu_on:     1'b1,
    sel_opt:     OPT_HORIZONTAL,
    cand_opt:    OPT_UPRIGHT,
    confirm_cnt: 3'd0,
    blink_cnt:   8'd0,
    switch_cnt:  6'd0,
    idle_cnt:    8'd0,
    last_yaw:    32'sd0,
    turning_pos: 1'b0
  };

  // |acc + 50 mg|, fits 16 bits unsigned
  function automatic logic [TILT_W-1:0] tilt_mg(input logic signed [ACC_W-1:0] acc);
    logic signed [TILT_W-1:0] s;
    s = $signed({acc[ACC_W-1], acc}) + TILT_OFFSET_MG;
    return s[TILT_W-1] ? TILT_W'(-s) : TILT_W'(s);
  endfunction

endpackage

// ----- rtl/sgm_if.sv -----
// valid/ready channel interfaces for sensor ticks and menu results
// depends on sgm_pkg for field widths
interface sgm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [sgm_pkg::TIME_W-1:0]            time_ms;
  logic signed [sgm_pkg::ACC_W-1:0]      acc_z_mg;
  logic signed [sgm_pkg::YAW_W-1:0]      yaw_deg;

  modport source (output valid, time_ms, acc_z_mg, yaw_deg, input ready);
  modport sink   (input valid, time_ms, acc_z_mg, yaw_deg, output ready);
endinterface

interface sgm_out_if;
  logic       valid;
  logic       ready;
  logic       menu_active;
  logic [1:0] option;
  logic [2:0] confirm_level;
  logic [5:0] reversal_count;

  modport source (output valid, menu_active, option, confirm_level, reversal_count,
                  input ready);
  modport sink   (input valid, menu_active, option, confirm_level, reversal_count,
                  output ready);
endinterface

// ----- rtl/spin_gesture_menu_controller.sv -----
// throughput: one tick per cycle while the output is not stalled; each tick is held in
// the input register, and one combinational pass of entry detection and menu logic
// feeds its result into the output register
// ready drops only while the output register holds an untaken beat and the
// input register is full; reset (rst_ni low, async) restores state, configuration and valid flags
module spin_gesture_menu_controller #(
  parameter int unsigned CONFIRM_PERIOD = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sgm_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  sgm_in_if.sink                            in_i,
  sgm_out_if.source                         out_o
);

  localparam int unsigned PHASE_W = (CONFIRM_PERIOD > 1) ? $clog2(CONFIRM_PERIOD) : 1;

  sgm_pkg::cfg_t cfg_q;
  sgm_pkg::st_t  st_q;
  sgm_pkg::st_t  st_entry;
  sgm_pkg::st_t  st_d;
  logic [PHASE_W-1:0] phase_q;
  logic [PHASE_W-1:0] phase_d;

  logic                                 s1_valid_q;
  logic [sgm_pkg::TIME_W-1:0]           s1_time_q;
  logic signed [sgm_pkg::ACC_W-1:0]     s1_acc_q;
  logic signed [sgm_pkg::YAW_W-1:0]     s1_yaw_q;

  logic       out_valid_q;
  logic       out_menu_q;
  logic [1:0] out_opt_q;
  logic [2:0] out_conf_q;
  logic [5:0] out_rev_q;

  logic [sgm_pkg::TILT_W-1:0] tilt;
  logic advance;
  logic in_beat;
  logic blink_clr;
  logic past_warmup;

  assign advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_beat  = in_i.valid && in_i.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= sgm_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        sgm_pkg::REG_WARMUP_MS:         cfg_q.warmup_ms         <= cfg_wdata_i;
        sgm_pkg::REG_REQUIRED_SWITCHES: cfg_q.required_switches <= cfg_wdata_i[5:0];
        sgm_pkg::REG_IDLE_TIMEOUT:      cfg_q.idle_timeout      <= cfg_wdata_i[7:0];
        sgm_pkg::REG_ANGLE_TOLERANCE:   cfg_q.angle_tolerance   <= cfg_wdata_i[8:0];
        sgm_pkg::REG_LEVEL_LIMIT_MG:    cfg_q.level_limit_mg    <= cfg_wdata_i[10:0];
        sgm_pkg::REG_CONFIRM_TARGET:    cfg_q.confirm_target    <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_time_q <= in_i.time_ms;
      s1_acc_q  <= in_i.acc_z_mg;
      s1_yaw_q  <= in_i.yaw_deg;
    end
  end

  assign tilt = sgm_pkg::tilt_mg(s1_acc_q);

  sgm_entry u_entry (
    .cfg_i         (cfg_q),
    .st_i          (st_q),
    .time_ms_i     (s1_time_q),
    .tilt_i        (tilt),
    .yaw_i         (s1_yaw_q),
    .st_o          (st_entry),
    .blink_clr_o   (blink_clr),
    .past_warmup_o (past_warmup)
  );

  sgm_menu #(
    .CONFIRM_PERIOD (CONFIRM_PERIOD)
  ) u_menu (
    .cfg_i         (cfg_q),
    .st_i          (st_entry),
    .tilt_i        (tilt),
    .past_warmup_i (past_warmup),
    .blink_clr_i   (blink_clr),
    .phase_i       (phase_q),
    .st_o          (st_d),
    .phase_o       (phase_d)
  );

  // state moves with each tick that reaches the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= sgm_pkg::ST_RESET;
      phase_q <= '0;
    end else if (advance) begin
      st_q    <= st_d;
      phase_q <= phase_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_menu_q <= st_d.menu_on;
      out_opt_q  <= st_d.sel_opt;
      out_conf_q <= st_d.confirm_cnt;
      out_rev_q  <= st_d.switch_cnt;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.menu_active    = out_menu_q;
  assign out_o.option         = out_opt_q;
  assign out_o.confirm_level  = out_conf_q;
  assign out_o.reversal_count = out_rev_q;

endmodule

// ----- rtl/sgm_entry.sv -----
// menu entry detection: warm-up, yaw reversal counting, idle timeout
// depends on sgm_pkg
module sgm_entry (
  input  sgm_pkg::cfg_t                      cfg_i,
  input  sgm_pkg::st_t                       st_i,
  input  logic [sgm_pkg::TIME_W-1:0]         time_ms_i,
  input  logic [sgm_pkg::TILT_W-1:0]         tilt_i,
  input  logic signed [sgm_pkg::YAW_W-1:0]   yaw_i,
  output sgm_pkg::st_t                       st_o,
  output logic                               blink_clr_o,
  output logic                               past_warmup_o
);

  logic signed [sgm_pkg::YAW_W:0] yaw_diff;
  logic signed [sgm_pkg::YAW_W:0] tol_s;
  logic                           turn_up;
  logic                           turn_dn;
  logic                           in_warmup;

  // one extra bit keeps the difference exact
  assign yaw_diff = $signed({yaw_i[sgm_pkg::YAW_W-1], yaw_i})
                  - $signed({st_i.last_yaw[sgm_pkg::YAW_W-1], st_i.last_yaw});
  assign tol_s    = $signed({24'd0, cfg_i.angle_tolerance});
  assign turn_up  = yaw_diff > tol_s;
  assign turn_dn  = yaw_diff < -tol_s;

  assign in_warmup     = time_ms_i < {16'd0, cfg_i.warmup_ms};
  assign past_warmup_o = time_ms_i > {16'd0, cfg_i.warmup_ms};

  always_comb begin
    st_o        = st_i;
    blink_clr_o = 1'b0;
    if (in_warmup) begin
      st_o.menu_on = 1'b1;
    end else begin
      if (st_i.idle_cnt != sgm_pkg::IDLE_MAX) begin
        st_o.idle_cnt = st_i.idle_cnt + 8'd1;
      end
      // staff not level
      if (tilt_i > {5'd0, cfg_i.level_limit_mg}) begin
        st_o.switch_cnt = 6'd0;
        st_o.idle_cnt   = 8'd0;
      end
      if (turn_up && !st_i.turning_pos) begin
        if (st_o.switch_cnt != sgm_pkg::SWITCH_MAX) begin
          st_o.switch_cnt = st_o.switch_cnt + 6'd1;
        end
        st_o.turning_pos = 1'b1;
        st_o.idle_cnt    = 8'd0;
      end else if (turn_dn && st_i.turning_pos) begin
        if (st_o.switch_cnt != sgm_pkg::SWITCH_MAX) begin
          st_o.switch_cnt = st_o.switch_cnt + 6'd1;
        end
        st_o.turning_pos = 1'b0;
        st_o.idle_cnt    = 8'd0;
      end
      st_o.last_yaw = yaw_i;
      if (st_o.switch_cnt == cfg_i.required_switches) begin
        st_o.menu_on     = 1'b1;
        st_o.idle_cnt    = 8'd0;
        st_o.switch_cnt  = 6'd0;
        st_o.blink_cnt   = 8'd0;
        st_o.confirm_cnt = 3'd0;
        blink_clr_o      = 1'b1;
      end
      if (st_o.idle_cnt > cfg_i.idle_timeout) begin
        st_o.idle_cnt   = 8'd0;
        st_o.switch_cnt = 6'd0;
      end
    end
  end

endmodule

// ----- rtl/sgm_menu.sv -----
// menu mode: option pick from tilt and periodic confirmation to leave
// depends on sgm_pkg
module sgm_menu #(
  parameter int unsigned CONFIRM_PERIOD = 8,
  localparam int unsigned PHASE_W = (CONFIRM_PERIOD > 1) ? $clog2(CONFIRM_PERIOD) : 1
) (
  input  sgm_pkg::cfg_t                cfg_i,
  input  sgm_pkg::st_t                 st_i,
  input  logic [sgm_pkg::TILT_W-1:0]   tilt_i,
  input  logic                         past_warmup_i,
  input  logic                         blink_clr_i,
  input  logic [PHASE_W-1:0]           phase_i,
  output sgm_pkg::st_t                 st_o,
  output logic [PHASE_W-1:0]           phase_o
);

  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(CONFIRM_PERIOD - 1);

  logic [PHASE_W-1:0] phase_base;
  logic [1:0]         sel;

  // phase tracks blink_cnt modulo the check period
  assign phase_base = blink_clr_i ? '0 : phase_i;

  always_comb begin
    priority if (tilt_i < sgm_pkg::TILT_LOW_MG) begin
      sel = sgm_pkg::OPT_HORIZONTAL;
    end else if (tilt_i > sgm_pkg::TILT_HIGH_MG) begin
      sel = sgm_pkg::OPT_UPRIGHT;
    end else begin
      sel = sgm_pkg::OPT_BETWEEN;
    end
  end

  always_comb begin
    st_o    = st_i;
    phase_o = phase_i;
    if (st_i.menu_on) begin
      st_o.sel_opt = sel;
      if (phase_base == '0 && past_warmup_i) begin
        if (st_i.cand_opt == sel) begin
          if (st_i.confirm_cnt != sgm_pkg::CONFIRM_MAX) begin
            st_o.confirm_cnt = st_i.confirm_cnt + 3'd1;
          end
        end else begin
          st_o.confirm_cnt = 3'd0;
          st_o.cand_opt    = sel;
        end
        if (st_o.confirm_cnt == cfg_i.confirm_target) begin
          st_o.menu_on    = 1'b0;
          st_o.idle_cnt   = 8'd0;
          st_o.switch_cnt = 6'd0;
        end
      end
      st_o.blink_cnt = st_i.blink_cnt + 8'd1;
      // wrap of the 8-bit blink counter restarts the phase too
      if (st_i.blink_cnt == sgm_pkg::BLINK_LAST || phase_base == PHASE_LAST) begin
        phase_o = '0;
      end else begin
        phase_o = phase_base + PHASE_W'(1);
      end
    end
  end

endmodule

// ----- rtl/sgm_checker.sv -----
// port-level checks of the spin gesture menu controller, bound to the top level
// depends on assert_macros.svh and sgm_pkg
`include "assert_macros.svh"

module sgm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       menu_active_i,
  input logic [1:0] option_i,
  input logic [2:0] confirm_level_i,
  input logic [5:0] reversal_count_i
);

  logic out_stall;
  assign out_stall = out_valid_i && !out_ready_i;

  `SGM_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i, "result beat dropped while stalled")

  `SGM_ASSERT_NEXT(a_out_stable, out_stall,
    $stable(menu_active_i) && $stable(option_i) && $stable(confirm_level_i)
    && $stable(reversal_count_i), "stalled result beat changed")

  `SGM_ASSERT_IMPL(a_opt_legal, out_valid_i,
    option_i == sgm_pkg::OPT_UPRIGHT || option_i == sgm_pkg::OPT_BETWEEN
    || option_i == sgm_pkg::OPT_HORIZONTAL, "option out of range")

  // an accepted tick passes the input register and yields a result beat when the sink is ready
  `SGM_ASSERT_NEXT(a_latency, (in_valid_i && in_ready_i) ##1 out_ready_i, out_valid_i,
    "accepted tick did not produce a result beat")

endmodule

bind spin_gesture_menu_controller sgm_checker u_sgm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .menu_active_i    (out_o.menu_active),
  .option_i         (out_o.option),
  .confirm_level_i  (out_o.confirm_level),
  .reversal_count_i (out_o.reversal_count)
);
